FILE: src/svcb_pkg.sv
`timescale 1ns / 1ps

package svcb_pkg;

  // Parameter keys that the parser knows
  localparam logic [15:0] PARAM_MANDATORY   = 16'd0;
  localparam logic [15:0] PARAM_ALPN        = 16'd1;
  localparam logic [15:0] PARAM_NO_DEF_ALPN = 16'd2;
  localparam logic [15:0] PARAM_PORT        = 16'd3;
  localparam logic [15:0] PARAM_IPV4_HINT   = 16'd4;
  localparam logic [15:0] PARAM_IPV6_HINT   = 16'd6;
  localparam logic [15:0] PARAM_DOH_PATH    = 16'd7;

  // Header is four bytes: key and length, most significant byte first
  localparam logic [1:0] HDR_LAST = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_VALUE  = 2'd1,
    PH_DRAIN  = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    KIND_PARAM_START = 4'd0,
    KIND_ALPN_BYTE   = 4'd1,
    KIND_ALPN_EMPTY  = 4'd2,
    KIND_PORT        = 4'd3,
    KIND_MAND_KEY    = 4'd4,
    KIND_IPV4        = 4'd5,
    KIND_IPV6_HALF   = 4'd6,
    KIND_DOH_BYTE    = 4'd7,
    KIND_DONE        = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_TRUNC = 3'd1,
    ST_ALPN  = 3'd2,
    ST_PORT  = 3'd3,
    ST_MAND  = 3'd4,
    ST_IPV4  = 3'd5,
    ST_IPV6  = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] bytes_left;
  } in_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic        element_end;
    logic [2:0]  status;
    logic        stream_last;
  } result_t;

  // Results produced by one accepted byte (count is 0, 1 or 2)
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

FILE: src/svcb_core.sv
`timescale 1ns / 1ps

module svcb_core import svcb_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  in_t   req,
  output push_t push
);

  phase_t      phase, phase_next;
  logic [1:0]  header_count, header_count_next;
  logic [15:0] param_key, param_key_next;
  logic [15:0] param_remaining, param_remaining_next;
  logic [7:0]  alpn_remaining, alpn_remaining_next;
  logic [63:0] assemble, assemble_next;
  logic [3:0]  assemble_count, assemble_count_next;

  logic [7:0]  b;
  logic [15:0] left;
  logic        last;
  logic        stop;
  status_t     st;
  logic        elem_vld;
  result_t     elem;
  result_t     done;

  assign b    = req.data_byte;
  assign left = 16'(req.bytes_left[COUNT_BITS-1:0]);
  assign last = (left == 16'd0);

  // Parse step: next state and the results of this byte
  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    param_key_next       = param_key;
    param_remaining_next = param_remaining;
    alpn_remaining_next  = alpn_remaining;
    assemble_next        = assemble;
    assemble_count_next  = assemble_count;
    stop     = 1'b0;
    st       = ST_OK;
    elem_vld = 1'b0;
    elem     = '0;
    done     = '0;

    case (phase)
      PH_HEADER: begin
        case (header_count)
          2'd0: param_key_next = {b, 8'h00};
          2'd1: param_key_next = {param_key[15:8], b};
          2'd2: param_remaining_next = {b, 8'h00};
          default: param_remaining_next = {param_remaining[15:8], b};
        endcase
        if (header_count != HDR_LAST) begin
          header_count_next = header_count + 2'd1;
        end else begin
          header_count_next = 2'd0;
          if (param_remaining_next > left) begin
            stop = 1'b1; st = ST_TRUNC;
          end else if (param_key_next == PARAM_MANDATORY && param_remaining_next[0]) begin
            stop = 1'b1; st = ST_MAND;
          end else if (param_key_next == PARAM_PORT && param_remaining_next != 16'd2) begin
            stop = 1'b1; st = ST_PORT;
          end else if (param_key_next == PARAM_IPV4_HINT &&
                       param_remaining_next[1:0] != 2'd0) begin
            stop = 1'b1; st = ST_IPV4;
          end else if (param_key_next == PARAM_IPV6_HINT &&
                       param_remaining_next[3:0] != 4'd0) begin
            stop = 1'b1; st = ST_IPV6;
          end else begin
            // Start mark only for known keys; unknown ones are skipped
            if (param_key_next <= PARAM_IPV4_HINT || param_key_next == PARAM_IPV6_HINT ||
                param_key_next == PARAM_DOH_PATH) begin
              elem_vld   = 1'b1;
              elem.kind  = KIND_PARAM_START;
              elem.value = 64'(param_key_next);
            end
            assemble_next       = '0;
            assemble_count_next = '0;
            alpn_remaining_next = '0;
            if (param_remaining_next != 16'd0) begin
              phase_next = PH_VALUE;
            end
          end
        end
      end

      PH_VALUE: begin
        param_remaining_next = param_remaining - 16'd1;
        case (param_key)
          PARAM_ALPN: begin
            if (alpn_remaining == 8'd0) begin
              if (16'(b) > param_remaining_next) begin
                stop = 1'b1; st = ST_ALPN;
              end else if (b == 8'd0) begin
                elem_vld         = 1'b1;
                elem.kind        = KIND_ALPN_EMPTY;
                elem.element_end = 1'b1;
              end else begin
                alpn_remaining_next = b;
              end
            end else begin
              alpn_remaining_next = alpn_remaining - 8'd1;
              elem_vld         = 1'b1;
              elem.kind        = KIND_ALPN_BYTE;
              elem.value       = 64'(b);
              elem.element_end = (alpn_remaining_next == 8'd0);
            end
          end
          PARAM_PORT, PARAM_MANDATORY: begin
            assemble_next       = {48'h0, assemble[7:0], b};
            assemble_count_next = assemble_count + 4'd1;
            if (assemble_count_next >= 4'd2) begin
              elem_vld            = 1'b1;
              elem.kind           = (param_key == PARAM_PORT) ? KIND_PORT : KIND_MAND_KEY;
              elem.value          = assemble_next;
              assemble_count_next = 4'd0;
            end
          end
          PARAM_IPV4_HINT: begin
            assemble_next       = {32'h0, assemble[23:0], b};
            assemble_count_next = assemble_count + 4'd1;
            if (assemble_count_next >= 4'd4) begin
              elem_vld            = 1'b1;
              elem.kind           = KIND_IPV4;
              elem.value          = assemble_next;
              assemble_count_next = 4'd0;
            end
          end
          PARAM_IPV6_HINT: begin
            assemble_next       = {assemble[55:0], b};
            assemble_count_next = assemble_count + 4'd1;
            // Halves close at byte 8 and byte 16 of each address
            if (assemble_count_next == 4'd8 || assemble_count_next == 4'd0) begin
              elem_vld         = 1'b1;
              elem.kind        = KIND_IPV6_HALF;
              elem.value       = assemble_next;
              elem.element_end = (assemble_count_next == 4'd0);
            end
          end
          PARAM_DOH_PATH: begin
            elem_vld         = 1'b1;
            elem.kind        = KIND_DOH_BYTE;
            elem.value       = 64'(b);
            elem.element_end = (param_remaining_next == 16'd0);
          end
          default: begin
          end
        endcase
        if (!stop && param_remaining_next == 16'd0) begin
          phase_next = PH_HEADER;
        end
      end

      default: begin
        // Drain: swallow the rest of the area
      end
    endcase

    if (phase != PH_DRAIN) begin
      if (!stop && last) begin
        stop = 1'b1;
        st   = (phase_next == PH_HEADER && header_count_next == 2'd0) ? ST_OK : ST_TRUNC;
      end
      if (stop) begin
        done.kind        = KIND_DONE;
        done.status      = st;
        done.stream_last = last;
        if (!last) begin
          phase_next = PH_DRAIN;
        end
      end
    end

    // Last byte of the area re-arms the parser
    if ((phase == PH_DRAIN || stop) && last) begin
      phase_next           = PH_HEADER;
      header_count_next    = '0;
      param_key_next       = '0;
      param_remaining_next = '0;
      alpn_remaining_next  = '0;
      assemble_next        = '0;
      assemble_count_next  = '0;
    end
  end

  // Pack the results of this byte, element first, done after
  always_comb begin
    push = '0;
    if (accept) begin
      if (elem_vld && stop) begin
        push.count = 2'd2;
        push.r0    = elem;
        push.r1    = done;
      end else if (elem_vld) begin
        push.count = 2'd1;
        push.r0    = elem;
      end else if (stop) begin
        push.count = 2'd1;
        push.r0    = done;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= '0;
      param_key       <= '0;
      param_remaining <= '0;
      alpn_remaining  <= '0;
      assemble        <= '0;
      assemble_count  <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      param_key       <= param_key_next;
      param_remaining <= param_remaining_next;
      alpn_remaining  <= alpn_remaining_next;
      assemble        <= assemble_next;
      assemble_count  <= assemble_count_next;
    end
  end

  a_drain_silent: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_DRAIN |-> push.count == 2'd0)
    else $error("result produced while draining");

  a_two_ends_done: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.r1.kind == KIND_DONE)
    else $error("second result of a byte is not done");

  a_hdr_count_phase: assert property (@(posedge clk) disable iff (rst)
    header_count != 2'd0 |-> phase == PH_HEADER)
    else $error("partial header outside header phase");

endmodule

FILE: src/svcb_param_parser.sv
`timescale 1ns / 1ps

// SVCB parameter area parser. Takes one byte of the SvcParams area per cycle,
// with the count of area bytes still to come, and emits parameter start marks,
// decoded elements (ALPN bytes, port, mandatory keys, IPv4/IPv6 hints, DoH path
// bytes) and one done result per area carrying the status. A byte is parsed in
// the cycle it is accepted and causes zero, one or two results; results leave
// through a four-entry queue at one per cycle while res_stall is low. Input is
// taken every cycle while the queue has room for two results, so the rate is
// one byte per cycle unless the result side stalls and the queue fills.
// COUNT_BITS sets how many low bits of bytes_left are used.
module svcb_param_parser import svcb_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    byte_valid,
  output logic    byte_stall,
  input  in_t     byte_req,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res_data
);

  localparam int QDEPTH = 4;

  push_t      push;
  logic       accept;
  logic       pop;
  result_t    queue [QDEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic [2:0] count_next;

  assign byte_stall = (count > 3'd2);
  assign accept     = byte_valid && !byte_stall;
  assign res_valid  = (count != 3'd0);
  assign pop        = res_valid && !res_stall;
  assign res_data   = queue[rd_ptr];

  svcb_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (byte_req),
    .push   (push)
  );

  // Result queue storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      queue[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      queue[wr_ptr + 2'd1] <= push.r1;
    end
  end

  // Queue pointers and fill level
  assign count_next = count + 3'(push.count) - 3'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(QDEPTH))
    else $error("result queue overflow");

  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.stream_last |-> res_data.kind == KIND_DONE)
    else $error("stream_last on a result other than done");

  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.kind != KIND_DONE |-> res_data.status == ST_OK)
    else $error("status set on a non-done result");

endmodule

FILE: tb/tb_svcb_param_parser.sv
`timescale 1ns / 1ps

module tb_svcb_param_parser;
  import svcb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          RANDOM_BYTES = 1950;
  localparam int          DRAIN_CYCLES = 20;

  // Tracks parser state and holds the results each accepted byte should produce
  class param_scoreboard;
    phase_t      phase = PH_HEADER;
    logic [1:0]  hdr_cnt = '0;
    logic [15:0] key = '0;
    logic [15:0] remaining = '0;
    logic [7:0]  alpn_left = '0;
    logic [63:0] acc = '0;
    logic [3:0]  acc_cnt = '0;
    result_t     pending_results[$];
    int          mismatches = 0;

    function void clear();
      phase     = PH_HEADER;
      hdr_cnt   = '0;
      key       = '0;
      remaining = '0;
      alpn_left = '0;
      acc       = '0;
      acc_cnt   = '0;
    endfunction

    function void push(kind_t k, logic [63:0] v, logic e, status_t s, logic l);
      result_t r;
      r.kind        = k;
      r.value       = v;
      r.element_end = e;
      r.status      = s;
      r.stream_last = l;
      pending_results = {pending_results, r};
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Advance the parser by one accepted byte
    function void predict_byte(in_t req);
      logic [7:0]  b;
      logic [15:0] left;
      logic        stop;
      status_t     st;
      b    = req.data_byte;
      left = req.bytes_left;
      stop = 1'b0;
      st   = ST_OK;

      // rest of a failed area is swallowed until its last byte
      if (phase == PH_DRAIN) begin
        if (left == 16'd0) clear();
        return;
      end

      if (phase == PH_HEADER) begin
        case (hdr_cnt)
          2'd0:    key = {b, 8'h00};
          2'd1:    key[7:0] = b;
          2'd2:    remaining = {b, 8'h00};
          default: remaining[7:0] = b;
        endcase
        if (hdr_cnt != HDR_LAST) begin
          hdr_cnt = hdr_cnt + 2'd1;
        end else begin
          hdr_cnt = '0;
          if (remaining > left) begin
            stop = 1'b1; st = ST_TRUNC;
          end else if (key == PARAM_MANDATORY && remaining[0]) begin
            stop = 1'b1; st = ST_MAND;
          end else if (key == PARAM_PORT && remaining != 16'd2) begin
            stop = 1'b1; st = ST_PORT;
          end else if (key == PARAM_IPV4_HINT && remaining[1:0] != 2'd0) begin
            stop = 1'b1; st = ST_IPV4;
          end else if (key == PARAM_IPV6_HINT && remaining[3:0] != 4'd0) begin
            stop = 1'b1; st = ST_IPV6;
          end else begin
            if (key <= PARAM_IPV4_HINT || key == PARAM_IPV6_HINT || key == PARAM_DOH_PATH)
              push(KIND_PARAM_START, {48'd0, key}, 1'b0, ST_OK, 1'b0);
            acc       = '0;
            acc_cnt   = '0;
            alpn_left = '0;
            if (remaining != 16'd0) phase = PH_VALUE;
          end
        end
      end else begin
        remaining = remaining - 16'd1;
        case (key)
          PARAM_ALPN: begin
            if (alpn_left == 8'd0) begin
              if ({8'd0, b} > remaining) begin
                stop = 1'b1; st = ST_ALPN;
              end else if (b == 8'd0) begin
                push(KIND_ALPN_EMPTY, 64'd0, 1'b1, ST_OK, 1'b0);
              end else begin
                alpn_left = b;
              end
            end else begin
              alpn_left = alpn_left - 8'd1;
              push(KIND_ALPN_BYTE, {56'd0, b}, alpn_left == 8'd0, ST_OK, 1'b0);
            end
          end
          PARAM_PORT, PARAM_MANDATORY: begin
            acc     = {48'd0, acc[7:0], b};
            acc_cnt = acc_cnt + 4'd1;
            if (acc_cnt >= 4'd2) begin
              push((key == PARAM_PORT) ? KIND_PORT : KIND_MAND_KEY, acc, 1'b0, ST_OK, 1'b0);
              acc_cnt = '0;
            end
          end
          PARAM_IPV4_HINT: begin
            acc     = {32'd0, acc[23:0], b};
            acc_cnt = acc_cnt + 4'd1;
            if (acc_cnt >= 4'd4) begin
              push(KIND_IPV4, acc, 1'b0, ST_OK, 1'b0);
              acc_cnt = '0;
            end
          end
          PARAM_IPV6_HINT: begin
            // 4-bit count wraps after the second half
            acc     = {acc[55:0], b};
            acc_cnt = acc_cnt + 4'd1;
            if (acc_cnt == 4'd8)
              push(KIND_IPV6_HALF, acc, 1'b0, ST_OK, 1'b0);
            else if (acc_cnt == 4'd0)
              push(KIND_IPV6_HALF, acc, 1'b1, ST_OK, 1'b0);
          end
          PARAM_DOH_PATH: push(KIND_DOH_BYTE, {56'd0, b}, remaining == 16'd0, ST_OK, 1'b0);
          default: ;
        endcase
        if (!stop && remaining == 16'd0) phase = PH_HEADER;
      end

      // end of area closes parsing; clean only on a header boundary
      if (!stop && left == 16'd0) begin
        stop = 1'b1;
        st   = (phase == PH_HEADER && hdr_cnt == 2'd0) ? ST_OK : ST_TRUNC;
      end
      if (stop) begin
        push(KIND_DONE, 64'd0, 1'b0, st, left == 16'd0);
        if (left == 16'd0) clear();
        else phase = PH_DRAIN;
      end
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result expected none actual %0h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind) report("kind", 64'(want.kind), 64'(got.kind));
      if (got.value !== want.value) report("value", want.value, got.value);
      if (got.element_end !== want.element_end)
        report("element_end", 64'(want.element_end), 64'(got.element_end));
      if (got.status !== want.status) report("status", 64'(want.status), 64'(got.status));
      if (got.stream_last !== want.stream_last)
        report("stream_last", 64'(want.stream_last), 64'(got.stream_last));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  in_t         byte_req;
  logic        res_valid;
  logic        res_stall = 1'b0;
  result_t     res_data;

  param_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int              sent = 0;
  logic            quiet = 1'b0;
  logic [7:0]      area_bytes[$];

  svcb_param_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Random back-pressure on the result side
  always @(posedge clk) begin
    res_stall <= !quiet && ($urandom_range(0, 99) < 20);
  end

  // Observe both handshakes; predict before checking within one edge
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) sb.predict_byte(byte_req);
      if (res_valid && !res_stall) sb.check_result(res_data);
    end
  end

  // Returns in the time step of the edge that accepted the request
  task automatic send_byte(input logic [7:0] d, input logic [15:0] left);
    while (!quiet && $urandom_range(0, 99) < 20) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid          <= 1'b1;
    byte_req.data_byte  <= d;
    byte_req.bytes_left <= left;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sent++;
  endtask

  // Counts down bytes_left; one byte may carry an inconsistent count
  task automatic send_area(input int bad_idx, input logic [15:0] bad_left);
    logic [15:0] left;
    for (int i = 0; i < area_bytes.size(); i++) begin
      left = 16'(area_bytes.size() - 1 - i);
      if (i == bad_idx) left = bad_left;
      send_byte(area_bytes[i], left);
    end
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic add_header(input logic [15:0] k, input logic [15:0] len);
    area_bytes = {area_bytes, k[15:8], k[7:0], len[15:8], len[7:0]};
  endtask

  // One well-formed parameter with random content
  task automatic add_param();
    logic [7:0]  val[$];
    logic [15:0] k;
    int          n;
    int          l;
    case ($urandom_range(0, 7))
      0: begin
        k = PARAM_MANDATORY;
        n = $urandom_range(0, 3);
        repeat (2 * n) val = {val, 8'($urandom_range(0, 255))};
      end
      1: begin
        k = PARAM_ALPN;
        n = $urandom_range(0, 3);
        repeat (n) begin
          l = $urandom_range(0, 5);
          val = {val, 8'(l)};
          repeat (l) val = {val, 8'($urandom_range(0, 255))};
        end
      end
      2: begin
        k = PARAM_NO_DEF_ALPN;
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) val = {val, 8'($urandom_range(0, 255))};
      end
      3: begin
        k = PARAM_PORT;
        repeat (2) val = {val, 8'($urandom_range(0, 255))};
      end
      4: begin
        k = PARAM_IPV4_HINT;
        repeat (4 * $urandom_range(0, 2)) val = {val, 8'($urandom_range(0, 255))};
      end
      5: begin
        k = PARAM_IPV6_HINT;
        repeat (16 * $urandom_range(0, 1)) val = {val, 8'($urandom_range(0, 255))};
      end
      6: begin
        k = PARAM_DOH_PATH;
        repeat ($urandom_range(0, 6)) val = {val, 8'($urandom_range(0, 255))};
      end
      default: begin
        k = ($urandom_range(0, 1) == 0) ? 16'd5 : 16'($urandom_range(8, 65535));
        repeat ($urandom_range(0, 4)) val = {val, 8'($urandom_range(0, 255))};
      end
    endcase
    add_header(k, 16'(val.size()));
    area_bytes = {area_bytes, val};
  endtask

  // A parameter whose length breaks a size rule, or an overlong alpn id
  task automatic add_bad_param();
    logic [15:0] k;
    int          len;
    case ($urandom_range(0, 4))
      0: begin k = PARAM_MANDATORY; len = 2 * $urandom_range(0, 3) + 1; end
      1: begin
        k   = PARAM_PORT;
        len = $urandom_range(0, 5);
        if (len == 2) len = 3;
      end
      2: begin k = PARAM_IPV4_HINT; len = 4 * $urandom_range(0, 1) + $urandom_range(1, 3); end
      3: begin k = PARAM_IPV6_HINT; len = 16 * $urandom_range(0, 1) + $urandom_range(1, 15); end
      default: begin k = PARAM_ALPN; len = $urandom_range(1, 6); end
    endcase
    add_header(k, 16'(len));
    if (k == PARAM_ALPN) begin
      area_bytes = {area_bytes, 8'($urandom_range(len, 255))};
      len--;
    end
    repeat (len) area_bytes = {area_bytes, 8'($urandom_range(0, 255))};
  endtask

  initial begin
    int kind_pick;
    int bad_idx;
    rst        = 1'b1;
    byte_valid = 1'b0;
    byte_req   = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: short header on a lone last byte
    send_byte(8'h00, 16'd0);
    // port with all-ones value, clean end
    area_bytes = '{8'h00, 8'h03, 8'h00, 8'h02, 8'hFF, 8'hFF};
    send_area(-1, '0);
    // port size error, then swallowed byte
    area_bytes = '{8'h00, 8'h03, 8'h00, 8'h01, 8'h5A};
    send_area(-1, '0);
    // alpn id longer than the rest of the value
    area_bytes = '{8'h00, 8'h01, 8'h00, 8'h02, 8'h05, 8'h00};
    send_area(-1, '0);
    // maximum length and count: value longer than the area
    send_byte(8'h00, 16'hFFFF);
    send_byte(8'h07, 16'hFFFE);
    send_byte(8'hFF, 16'hFFFD);
    send_byte(8'hFF, 16'hFFFC);
    send_byte(8'h3C, 16'd0);

    // Random areas: mostly well formed, some broken, some noise
    while (sent < RANDOM_BYTES + 23) begin
      quiet = (sent > 700 && sent < 1100);
      if (sent > 1200 && sent < 1260) wait_drained();
      kind_pick = $urandom_range(0, 99);
      area_bytes.delete();
      if (kind_pick < 75) begin
        repeat ($urandom_range(1, 4)) add_param();
        send_area(-1, '0);
      end else if (kind_pick < 90) begin
        repeat ($urandom_range(0, 2)) add_param();
        bad_idx = -1;
        case ($urandom_range(0, 3))
          0: begin
            add_param();
            repeat ($urandom_range(1, area_bytes.size() - 1)) void'(area_bytes.pop_back());
          end
          1: begin
            add_param();
            area_bytes[$urandom_range(0, area_bytes.size() - 1)] = 8'($urandom_range(0, 255));
          end
          2: begin
            add_param();
            add_param();
            bad_idx = $urandom_range(0, area_bytes.size() - 2);
          end
          default: begin
            add_bad_param();
            if ($urandom_range(0, 1) == 1) add_param();
          end
        endcase
        send_area(bad_idx, 16'($urandom_range(0, 65535)));
      end else begin
        repeat ($urandom_range(1, 8))
          send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        send_byte(8'($urandom_range(0, 255)), 16'd0);
      end
    end

    quiet = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
